// File: rtl/rts_pkg.sv
// Shared constants, codes and control structs for the retransmit timer scan block.
`default_nettype none
package rts_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int NUM_BUFFERS  = 4;
  localparam int MAX_RETRIES  = 4;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int TMR_N  = NUM_CHANNELS * NUM_BUFFERS;
  localparam int TMR_W  = (TMR_N > 1) ? $clog2(TMR_N) : 1;
  localparam int RTY_W  = $clog2(MAX_RETRIES + 1);

  // Fixed field widths of the channels and the configuration port
  localparam int KIND_W    = 2;
  localparam int FLD_CH_W  = 3;
  localparam int FLD_BUF_W = 2;
  localparam int TIMER_W   = 15;
  localparam int EVENT_W   = 2;
  localparam int RATE_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 15;

  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_RX    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_TX    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SET_START = 2'd3;

  localparam logic [EVENT_W-1:0] EV_RX_TIMEOUT = 2'd0;
  localparam logic [EVENT_W-1:0] EV_RETRANSMIT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_SCAN_DONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTX_TIMEOUT = 1'd1;

  localparam logic [RATE_W-1:0]  RATE_RESET = 8'd1;
  localparam logic [TIMER_W-1:0] RTX_RESET  = 15'd3;

  typedef struct packed {
    logic load;     // accept the input transaction
    logic rx_step;  // update the receive timer
    logic tx_step;  // update one transmit timer and advance the scan
    logic fin;      // issue the scan-finished result
  } rts_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic rx_expire;
    logic tx_expire;
    logic scan_last;
    logic out_free;
  } rts_sts_t;

endpackage
`default_nettype wire

// File: rtl/rts_in_if.sv
// Input transaction channel: valid/ready plus the command payload.
`default_nettype none
interface rts_in_if;
  logic                           valid;
  logic                           ready;
  logic [rts_pkg::KIND_W-1:0]     kind;
  logic                           data_pending;
  logic [rts_pkg::FLD_CH_W-1:0]   channel;
  logic [rts_pkg::FLD_BUF_W-1:0]  buffer;
  logic [rts_pkg::TIMER_W-1:0]    timer_value;

  modport source (output valid, kind, data_pending, channel, buffer, timer_value,
                  input ready);
  modport sink   (input valid, kind, data_pending, channel, buffer, timer_value,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/rts_out_if.sv
// Result transaction channel: valid/ready plus the event payload.
`default_nettype none
interface rts_out_if;
  logic                           valid;
  logic                           ready;
  logic [rts_pkg::EVENT_W-1:0]    event_res;
  logic [rts_pkg::FLD_CH_W-1:0]   out_channel;
  logic [rts_pkg::FLD_BUF_W-1:0]  out_buffer;
  logic                           timers_active;
  logic                           last;

  modport source (output valid, event_res, out_channel, out_buffer, timers_active, last,
                  input ready);
  modport sink   (input valid, event_res, out_channel, out_buffer, timers_active, last,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/rts_datapath.sv
// Timer storage, scan counters, configuration registers and result register.
`default_nettype none
module rts_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rts_in_if.sink                               in_chan,
  rts_out_if.source                            out_chan,
  input  wire logic                            in_ready,
  input  wire logic                            cfg_we,
  input  wire logic [rts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rts_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire rts_pkg::rts_cmd_t               cmd,
  output rts_pkg::rts_sts_t                    sts
);

  logic [rts_pkg::RATE_W-1:0]    rate_r;
  logic [rts_pkg::TIMER_W-1:0]   rtx_r;
  logic [rts_pkg::TIMER_W-1:0]   rx_r;
  logic                          pend_r;
  logic [rts_pkg::TIMER_W-1:0]   tmr_r   [rts_pkg::TMR_N];
  logic [rts_pkg::BUF_W-1:0]     start_r [rts_pkg::NUM_CHANNELS];
  logic [rts_pkg::CH_W-1:0]      ch_r;
  logic [rts_pkg::BUF_W-1:0]     b_r;
  logic [rts_pkg::BUF_W-1:0]     cnt_r;
  logic [rts_pkg::RTY_W-1:0]     rty_r;
  logic                          act_r;

  logic                          ov_r;
  logic [rts_pkg::EVENT_W-1:0]   oev_r;
  logic [rts_pkg::FLD_CH_W-1:0]  och_r;
  logic [rts_pkg::FLD_BUF_W-1:0] obf_r;
  logic                          oact_r;
  logic                          olast_r;

  logic [rts_pkg::TMR_W-1:0]     tmr_idx;
  logic [rts_pkg::TMR_W-1:0]     wr_idx;
  logic [rts_pkg::TIMER_W-1:0]   tcur;
  logic [rts_pkg::TIMER_W-1:0]   rate_ext;
  logic [rts_pkg::BUF_W-1:0]     b_inc;
  logic [rts_pkg::CH_W-1:0]      ch_inc;
  logic                          ch_end;
  logic                          buf_end;
  logic                          slot_ok;
  logic                          start_ok;

  assign in_chan.ready = in_ready;

  assign rate_ext = rts_pkg::TIMER_W'(rate_r);
  assign tmr_idx  = rts_pkg::TMR_W'(32'(ch_r) * rts_pkg::NUM_BUFFERS + 32'(b_r));
  assign wr_idx   = rts_pkg::TMR_W'(32'(in_chan.channel) * rts_pkg::NUM_BUFFERS
                                    + 32'(in_chan.buffer));
  assign tcur     = tmr_r[tmr_idx];
  assign ch_end   = (32'(ch_r) == rts_pkg::NUM_CHANNELS - 1);
  assign buf_end  = (32'(cnt_r) == rts_pkg::NUM_BUFFERS - 1);
  assign b_inc    = (32'(b_r) == rts_pkg::NUM_BUFFERS - 1) ? '0 : b_r + 1'b1;
  assign ch_inc   = ch_end ? '0 : ch_r + 1'b1;
  assign slot_ok  = (32'(in_chan.channel) < rts_pkg::NUM_CHANNELS) &&
                    (32'(in_chan.buffer) < rts_pkg::NUM_BUFFERS);
  assign start_ok = slot_ok;

  always_comb begin
    sts.in_valid  = in_chan.valid;
    sts.in_tick   = (in_chan.kind == rts_pkg::KIND_TICK);
    sts.rx_expire = (rx_r != '0) && !pend_r && (rx_r <= rate_ext);
    sts.tx_expire = (tcur != '0) && (tcur <= rate_ext);
    sts.scan_last = (ch_end && buf_end) ||
                    (sts.tx_expire && (32'(rty_r) == rts_pkg::MAX_RETRIES - 1));
    sts.out_free  = !ov_r || out_chan.ready;
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.event_res     = oev_r;
  assign out_chan.out_channel   = och_r;
  assign out_chan.out_buffer    = obf_r;
  assign out_chan.timers_active = oact_r;
  assign out_chan.last          = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= rts_pkg::RATE_RESET;
      rtx_r  <= rts_pkg::RTX_RESET;
      rx_r   <= '0;
      pend_r <= 1'b0;
      for (int i = 0; i < rts_pkg::TMR_N; i++) tmr_r[i] <= '0;
      for (int i = 0; i < rts_pkg::NUM_CHANNELS; i++) start_r[i] <= '0;
      ch_r   <= '0;
      b_r    <= '0;
      cnt_r  <= '0;
      rty_r  <= '0;
      act_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rts_pkg::CFG_SCAN_RATE:   rate_r <= rts_pkg::RATE_W'(cfg_wdata);
          rts_pkg::CFG_RTX_TIMEOUT: rtx_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once the sink takes it, unless a new one is loaded below.
      if (ov_r && out_chan.ready && !(cmd.rx_step && sts.rx_expire) &&
          !(cmd.tx_step && sts.tx_expire) && !cmd.fin) begin
        ov_r <= 1'b0;
      end

      if (cmd.load) begin
        unique case (in_chan.kind)
          rts_pkg::KIND_TICK: begin
            pend_r <= in_chan.data_pending;
            ch_r   <= '0;
            cnt_r  <= '0;
            b_r    <= start_r[0];
            rty_r  <= '0;
            act_r  <= 1'b0;
          end
          rts_pkg::KIND_SET_RX: rx_r <= in_chan.timer_value;
          rts_pkg::KIND_SET_TX: if (slot_ok) tmr_r[wr_idx] <= in_chan.timer_value;
          rts_pkg::KIND_SET_START: begin
            if (start_ok) begin
              start_r[rts_pkg::CH_W'(in_chan.channel)] <= rts_pkg::BUF_W'(in_chan.buffer);
            end
          end
          default: ;
        endcase
      end

      if (cmd.rx_step && (rx_r != '0)) begin
        act_r <= 1'b1;
        if (!pend_r) begin
          if (sts.rx_expire) begin
            rx_r    <= '0;
            ov_r    <= 1'b1;
            oev_r   <= rts_pkg::EV_RX_TIMEOUT;
            och_r   <= '0;
            obf_r   <= '0;
            oact_r  <= 1'b0;
            olast_r <= 1'b0;
          end else begin
            rx_r <= rx_r - rate_ext;
          end
        end
      end

      if (cmd.tx_step) begin
        if (tcur != '0) begin
          act_r <= 1'b1;
          if (sts.tx_expire) begin
            tmr_r[tmr_idx] <= rtx_r;
            rty_r   <= rty_r + 1'b1;
            ov_r    <= 1'b1;
            oev_r   <= rts_pkg::EV_RETRANSMIT;
            och_r   <= rts_pkg::FLD_CH_W'(ch_r);
            obf_r   <= rts_pkg::FLD_BUF_W'(b_r);
            oact_r  <= 1'b0;
            olast_r <= 1'b0;
          end else begin
            tmr_r[tmr_idx] <= tcur - rate_ext;
          end
        end
        // Advance circularly within the channel, then to the next channel's start.
        if (buf_end) begin
          cnt_r <= '0;
          ch_r  <= ch_inc;
          b_r   <= start_r[ch_inc];
        end else begin
          cnt_r <= cnt_r + 1'b1;
          b_r   <= b_inc;
        end
      end

      if (cmd.fin) begin
        ov_r    <= 1'b1;
        oev_r   <= rts_pkg::EV_SCAN_DONE;
        och_r   <= '0;
        obf_r   <= '0;
        oact_r  <= act_r;
        olast_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/rts_ctrl.sv
// Scan sequencer: accepts transactions and steps the datapath through a tick.
`default_nettype none
module rts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rts_pkg::rts_sts_t   sts,
  output rts_pkg::rts_cmd_t        cmd,
  output logic                     in_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RX   = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_tick) state_nxt = ST_RX;
        end
      end
      ST_RX: begin
        // Hold while a timeout needs the result register and it is still full.
        if (!sts.rx_expire || sts.out_free) begin
          cmd.rx_step = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.tx_expire || sts.out_free) begin
          cmd.tx_step = 1'b1;
          if (sts.scan_last) state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/retransmit_timer_scan.sv
// Top level of the retransmit timer scan: sequencer plus timer datapath.
//
//   channel  | direction | transfer                    | payload
//   ---------+-----------+-----------------------------+--------------------------------------
//   in_chan  | sink      | valid & ready               | kind, data_pending, channel, buffer,
//            |           |                             | timer_value
//   out_chan | source    | valid & ready               | event_res, out_channel, out_buffer,
//            |           |                             | timers_active, last
//   cfg_*    | sink      | cfg_we (no back-pressure)   | cfg_index, cfg_wdata
//
// Arm, disarm and start-index transactions are applied as they are accepted.
// A tick steps the receive timer, then the transmit timers, then the finish; the
// single timer update unit visits one transmit timer per cycle while no full result
// register stalls it, and an early stop at the retry limit cuts the walk short.
// Each result occupies the one-entry output register; a full register stalls
// the scan only at a step that must emit. Reset (synchronous, rst_n low)
// clears all timers, start indexes and configuration to their defaults at once.
`default_nettype none
module retransmit_timer_scan (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rts_in_if.sink                               in_chan,
  rts_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [rts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rts_pkg::CFG_W-1:0]       cfg_wdata
);

  rts_pkg::rts_cmd_t cmd;
  rts_pkg::rts_sts_t sts;
  logic              in_ready;

  // Sequencer: one state per phase of a tick (receive timer, buffer walk, finish).
  rts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Datapath: timers, scan position, retry count and the result register.
  rts_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef NO_ASSERTIONS
  // The sequencer issues at most one datapath operation per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rx_step, cmd.tx_step, cmd.fin}))
    else $error("more than one datapath command in a cycle");

  // A retransmit is never written into an occupied result register.
  a_tx_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tx_step && sts.tx_expire) |-> sts.out_free)
    else $error("retransmit emitted into a full result register");

  // No transaction is accepted while a tick is being scanned.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tx_step || cmd.rx_step || cmd.fin) |-> !in_chan.ready)
    else $error("input accepted during a scan");

  // The scan-finished command always leaves a final result pending.
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (out_chan.valid && out_chan.last &&
                 out_chan.event_res == rts_pkg::EV_SCAN_DONE))
    else $error("scan finish did not produce a final result");
`endif

endmodule
`default_nettype wire

// File: tb/rts_tb_pkg.sv
// Scoreboard class with the timer scan predictor used by the retransmit timer scan testbench.
`timescale 1ns / 100ps
package rts_tb_pkg;
  import rts_pkg::*;

  typedef struct packed {
    logic [EVENT_W-1:0]   ev;
    logic [FLD_CH_W-1:0]  chan;
    logic [FLD_BUF_W-1:0] slot;
    logic                 active;
    logic                 last;
  } timer_event_t;

  class timer_scoreboard;
    logic [RATE_W-1:0]  scan_rate;
    logic [TIMER_W-1:0] rtx_reload;
    logic [15:0]        rx_timer;
    logic [15:0]        tx_timer [NUM_CHANNELS][NUM_BUFFERS];
    logic [BUF_W-1:0]   start_idx [NUM_CHANNELS];
    timer_event_t       due_events [$];
    int                 errors;

    function new();
      scan_rate  = RATE_RESET;
      rtx_reload = RTX_RESET;
      rx_timer   = '0;
      foreach (tx_timer[c, b]) tx_timer[c][b] = '0;
      foreach (start_idx[c]) start_idx[c] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_SCAN_RATE) scan_rate = val[RATE_W-1:0];
      else rtx_reload = val[TIMER_W-1:0];
    endfunction

    function void queue_event(logic [EVENT_W-1:0] ev, int chan, int slot, bit active,
                              bit last);
      timer_event_t e;
      e.ev     = ev;
      e.chan   = chan[FLD_CH_W-1:0];
      e.slot   = slot[FLD_BUF_W-1:0];
      e.active = active;
      e.last   = last;
      due_events.push_back(e);
    endfunction

    // Walk the receive timer, then every channel from its start index, and
    // stop once the retry limit is hit.
    function void scan_tick(logic pend);
      int  remain;
      int  retries;
      int  b;
      bit  any;
      retries = 0;
      any     = 1'b0;
      if (rx_timer != 0) begin
        any = 1'b1;
        if (!pend) begin
          remain = int'(rx_timer) - int'(scan_rate);
          if (remain <= 0) begin
            rx_timer = '0;
            queue_event(EV_RX_TIMEOUT, 0, 0, 1'b0, 1'b0);
          end else begin
            rx_timer = 16'(remain);
          end
        end
      end
      for (int c = 0; c < NUM_CHANNELS && retries < MAX_RETRIES; c++) begin
        b = int'(start_idx[c]);
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (tx_timer[c][b] != 0) begin
            any    = 1'b1;
            remain = int'(tx_timer[c][b]) - int'(scan_rate);
            if (remain <= 0) begin
              tx_timer[c][b] = {1'b0, rtx_reload};
              queue_event(EV_RETRANSMIT, c, b, 1'b0, 1'b0);
              retries++;
              if (retries >= MAX_RETRIES) break;
            end else begin
              tx_timer[c][b] = 16'(remain);
            end
          end
          b = (b + 1) % NUM_BUFFERS;
        end
      end
      queue_event(EV_SCAN_DONE, 0, 0, any, 1'b1);
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic pend, logic [FLD_CH_W-1:0] ch,
                            logic [FLD_BUF_W-1:0] bf, logic [TIMER_W-1:0] tv);
      case (kind)
        KIND_SET_RX: rx_timer = {1'b0, tv};
        KIND_SET_TX: begin
          if (ch < NUM_CHANNELS && bf < NUM_BUFFERS) tx_timer[ch][bf] = {1'b0, tv};
        end
        KIND_SET_START: begin
          if (ch < NUM_CHANNELS && bf < NUM_BUFFERS) start_idx[ch] = bf;
        end
        default: scan_tick(pend);
      endcase
    endfunction

    task check_event(timer_event_t got);
      timer_event_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected result ev=%0d ch=%0d buf=%0d act=%0d last=%0d",
                         got.ev, got.chan, got.slot, got.active, got.last));
        return;
      end
      want = due_events.pop_front();
      if (got.ev !== want.ev || got.chan !== want.chan || got.slot !== want.slot ||
          got.active !== want.active || got.last !== want.last) begin
        report($sformatf("got ev=%0d ch=%0d buf=%0d act=%0d last=%0d, want %0d %0d %0d %0d %0d",
                         got.ev, got.chan, got.slot, got.active, got.last,
                         want.ev, want.chan, want.slot, want.active, want.last));
      end
    endtask
  endclass

endpackage

// File: tb/retransmit_timer_scan_tb.sv
// Top-level testbench of the retransmit timer scan: stimulus, result sink and scoreboard.
`timescale 1ns / 100ps
module retransmit_timer_scan_tb;
  import rts_pkg::*;
  import rts_tb_pkg::*;

  // Cycles to let pass once nothing is expected: a full tick plus margin.
  localparam int SETTLE_CYCLES = 3 + NUM_CHANNELS * NUM_BUFFERS + 12;
  // Receiver hold-off used to fill the block and back up its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int END_WAIT      = 20000;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  idle_mode_t      idle_mode = IDLE_NONE;
  int              hold_req  = 0;
  timer_scoreboard sb        = new();

  rts_in_if  in_if ();
  rts_out_if out_if ();

  retransmit_timer_scan u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Run-time limit, far above the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("[retransmit_timer_scan] ERROR");
    $finish;
  end

  // Monitor: at each edge, feed the predictor with an accepted input
  // transaction first, then check an accepted result transaction.
  always @(posedge clk) begin : monitor
    timer_event_t seen;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_if.kind, in_if.data_pending, in_if.channel, in_if.buffer,
                     in_if.timer_value);
      end
      if (out_if.valid && out_if.ready) begin
        seen.ev     = out_if.event_res;
        seen.chan   = out_if.out_channel;
        seen.slot   = out_if.out_buffer;
        seen.active = out_if.timers_active;
        seen.last   = out_if.last;
        sb.check_event(seen);
      end
    end
  end

  // Result sink: stall at random per the idle mode; on request, hold ready
  // low for a long stretch so the block fills up.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >=
                         ((idle_mode == IDLE_RECEIVER) ? 58 :
                          (idle_mode == IDLE_BOTH) ? 28 : 0));
      end
    end
  end

  // Offer one transaction and return at the edge that accepts it. Valid stays
  // high on return so a back-to-back transaction never toggles it in one step.
  task automatic send_item(logic [KIND_W-1:0] kind, logic pend, logic [FLD_CH_W-1:0] ch,
                           logic [FLD_BUF_W-1:0] bf, logic [TIMER_W-1:0] tv);
    while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 58 :
                                 (idle_mode == IDLE_BOTH) ? 28 : 0)) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.data_pending <= pend;
    in_if.channel      <= ch;
    in_if.buffer       <= bf;
    in_if.timer_value  <= tv;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // Drop valid, give the monitor one edge to note the last transaction, wait
  // until every expected result is in, then let the block settle before any
  // register write.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; call only while idle.
  task automatic write_config(logic [RATE_W-1:0] rate, logic [TIMER_W-1:0] reload);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCAN_RATE;
    cfg_wdata <= CFG_W'(rate);
    @(posedge clk);
    sb.set_register(CFG_SCAN_RATE, CFG_W'(rate));
    cfg_index <= CFG_RTX_TIMEOUT;
    cfg_wdata <= reload;
    @(posedge clk);
    sb.set_register(CFG_RTX_TIMEOUT, reload);
    cfg_we <= 1'b0;
  endtask

  // Random transaction: mostly arming with values near the scan rate so
  // timers really expire, some disarms, some full-range values.
  task automatic send_random_item(int rate, int tick_pct);
    int                 pick;
    int                 span;
    logic [KIND_W-1:0]  kind;
    logic [TIMER_W-1:0] tv;
    pick = $urandom_range(99);
    if (pick < tick_pct) begin
      kind = KIND_TICK;
    end else begin
      pick = $urandom_range(99);
      kind = (pick < 62) ? KIND_SET_TX : (pick < 80) ? KIND_SET_RX : KIND_SET_START;
    end
    span = 4 * rate + 4;
    pick = $urandom_range(99);
    if (pick < 15) tv = '0;
    else if (pick < 75) tv = TIMER_W'($urandom_range(1, span));
    else tv = TIMER_W'($urandom());
    send_item(kind, ($urandom_range(99) < 30), FLD_CH_W'($urandom_range(7)),
              FLD_BUF_W'($urandom_range(3)), tv);
  endtask

  task automatic run_phase(logic [RATE_W-1:0] rate, logic [TIMER_W-1:0] reload,
                           idle_mode_t mode, int n_items, int tick_pct, bit squeeze);
    drain();
    write_config(rate, reload);
    idle_mode = mode;
    if (squeeze) hold_req <= hold_req + 1;
    repeat (n_items) send_random_item(int'(rate), tick_pct);
  endtask

  initial begin : stimulus
    int wait_cycles;
    wait_cycles = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SCAN_RATE;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_TICK;
    in_if.data_pending <= 1'b0;
    in_if.channel      <= '0;
    in_if.buffer       <= '0;
    in_if.timer_value  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration (rate 1, reload 3).
    // Tick with nothing armed: only a scan-finished result, nothing active.
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    // Receive timer: held while data is pending, then counted down to timeout.
    send_item(KIND_SET_RX, 1'b0, 3'd0, 2'd0, 15'd2);
    send_item(KIND_TICK, 1'b1, 3'd0, 2'd0, 15'd0);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    // Circular scan from a moved start index, corner slots of the table.
    send_item(KIND_SET_TX, 1'b0, 3'd0, 2'd0, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd7, 2'd3, 15'd1);
    send_item(KIND_SET_START, 1'b0, 3'd0, 2'd2, 15'd0);
    send_item(KIND_SET_TX, 1'b0, 3'd0, 2'd1, 15'd1);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    send_item(KIND_SET_START, 1'b1, 3'd7, 2'd3, 15'h7FFF);
    // Disarm with a zero value.
    send_item(KIND_SET_TX, 1'b0, 3'd0, 2'd0, 15'd0);
    send_item(KIND_SET_TX, 1'b0, 3'd0, 2'd1, 15'd0);
    send_item(KIND_SET_TX, 1'b0, 3'd7, 2'd3, 15'd0);
    // Retry limit: six timers expire at once, the scan stops after four and
    // leaves the last two untouched.
    send_item(KIND_SET_TX, 1'b0, 3'd1, 2'd0, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd2, 2'd1, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd3, 2'd2, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd4, 2'd3, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd5, 2'd0, 15'd1);
    send_item(KIND_SET_TX, 1'b0, 3'd6, 2'd2, 15'd1);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    // Largest timer values.
    send_item(KIND_SET_RX, 1'b0, 3'd0, 2'd0, 15'h7FFF);
    send_item(KIND_SET_TX, 1'b0, 3'd7, 2'd0, 15'h7FFF);
    send_item(KIND_TICK, 1'b1, 3'd7, 2'd3, 15'h7FFF);

    // Largest scan rate with a zero reload: expired timers report and go idle.
    drain();
    write_config(8'd255, 15'd0);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);

    // Zero scan rate: active timers hold and never expire.
    drain();
    write_config(8'd0, 15'h7FFF);
    send_item(KIND_SET_TX, 1'b0, 3'd2, 2'd2, 15'd1);
    send_item(KIND_TICK, 1'b0, 3'd0, 2'd0, 15'd0);

    // Random phases across rates, reloads and idle patterns.
    run_phase(8'd1, 15'd3, IDLE_NONE, 50, 30, 1'b0);
    run_phase(8'd7, 15'd20, IDLE_SENDER, 50, 30, 1'b0);
    run_phase(8'd255, 15'h7FFF, IDLE_RECEIVER, 50, 30, 1'b0);
    run_phase(8'd3, 15'd0, IDLE_BOTH, 50, 30, 1'b0);
    // Back-pressure: sink holds off while ticks keep coming.
    run_phase(8'd2, 15'd5, IDLE_NONE, 50, 45, 1'b1);

    // Let the monitor note the last transaction, wait for the last results
    // with a limit, then let the block settle.
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_events.size() != 0 && wait_cycles < END_WAIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.due_events.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.due_events.size()));
    end
    if (sb.errors == 0) begin
      $display("[retransmit_timer_scan] OK");
    end else begin
      $display("[retransmit_timer_scan] ERROR");
    end
    $finish;
  end

endmodule

// File: retransmit_timer_scan.f
rtl/rts_pkg.sv
rtl/rts_in_if.sv
rtl/rts_out_if.sv
rtl/rts_datapath.sv
rtl/rts_ctrl.sv
rtl/retransmit_timer_scan.sv
tb/rts_tb_pkg.sv
tb/retransmit_timer_scan_tb.sv
